### rtl/telephone_tone_generator_top_assert.svh
// Assertion macros for the tone generator top level.
`ifndef TELEPHONE_TONE_GENERATOR_TOP_ASSERT_SVH
`define TELEPHONE_TONE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TTG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tone generator assertion failed");

// Next-cycle implication, disabled in reset.
`define TTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tone generator assertion failed");

`endif

### rtl/ttg_pkg.sv
package ttg_pkg;

    localparam int SAMPLE_RATE = 8000;
    localparam int TIME_WIDTH  = 32;

    localparam int R8_W        = $clog2(SAMPLE_RATE);
    localparam int RING_CYCLE     = 4 * SAMPLE_RATE;
    localparam int RINGING_PERIOD = 5 * SAMPLE_RATE;
    localparam int CHOP_PERIOD    = (88 * SAMPLE_RATE) / 2000;
    localparam int RING_W      = $clog2(RING_CYCLE);
    localparam int RINGING_W   = $clog2(RINGING_PERIOD);
    localparam int CHOP_W      = $clog2(CHOP_PERIOD);

    localparam logic [TIME_WIDTH-1:0] RECIP_RING =
        TIME_WIDTH'((64'd1 << TIME_WIDTH) / RING_CYCLE);
    localparam logic [TIME_WIDTH-1:0] RECIP_RINGING =
        TIME_WIDTH'((64'd1 << TIME_WIDTH) / RINGING_PERIOD);
    localparam logic [TIME_WIDTH-1:0] RECIP_CHOP =
        TIME_WIDTH'((64'd1 << TIME_WIDTH) / CHOP_PERIOD);

    localparam int FADE_LEN    = (3 * SAMPLE_RATE) / 1000;
    localparam int ON_LEN      = (1300 * SAMPLE_RATE) / 1000;
    localparam int CHOP_RAMP   = (3 * SAMPLE_RATE) / 2000;
    localparam int CHOP_HALF   = CHOP_PERIOD / 2;
    localparam int RAMP_IDX_W  = $clog2(FADE_LEN);

    localparam int FREQ_W      = 11;
    localparam int X_W         = FREQ_W + R8_W;
    localparam int PH_NUM_W    = R8_W + 16;
    localparam logic [X_W-1:0] RECIP_X =
        X_W'((64'd1 << X_W) / SAMPLE_RATE);
    localparam logic [PH_NUM_W-1:0] RECIP_PH =
        PH_NUM_W'((64'd1 << PH_NUM_W) / SAMPLE_RATE);

    localparam logic [FREQ_W-1:0] F_RING    = 11'd1300;
    localparam logic [FREQ_W-1:0] F_RINGING = 11'd425;

    localparam int QD       = 8;
    localparam int QCNT_W   = $clog2(QD + 1);
    localparam int QPTR_W   = $clog2(QD);

    typedef enum logic [1:0] {
        OP_RING    = 2'd0,
        OP_TEST    = 2'd1,
        OP_RINGING = 2'd2,
        OP_TOUCH   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_ONE  = 2'd0,
        OUT_ZERO = 2'd1,
        OUT_COS  = 2'd2
    } outer_t;

    typedef enum logic [1:0] {
        IN_ONE  = 2'd0,
        IN_ZERO = 2'd1,
        IN_RISE = 2'd2,
        IN_FALL = 2'd3
    } inner_t;

    typedef struct packed {
        op_t                   op;
        logic [FREQ_W-1:0]     f1;
        logic [FREQ_W-1:0]     f2;
        logic [R8_W-1:0]       r8;
        logic                  ring_on;
        outer_t                outer;
        logic [RAMP_IDX_W-1:0] outer_n;
        inner_t                inner;
        logic [RAMP_IDX_W-1:0] inner_n;
    } job_t;

    typedef logic [15:0] ramp_tbl_t [2**RAMP_IDX_W];

    function automatic ramp_tbl_t build_ramp();
        ramp_tbl_t t;
        for (int i = 0; i < 2**RAMP_IDX_W; i++) begin
            t[i] = 16'((longint'(i) * 32768000) / (3 * SAMPLE_RATE));
        end
        return t;
    endfunction

    localparam ramp_tbl_t RAMP_TBL = build_ramp();

    localparam logic [14:0] QSINE [33] = '{
        15'd0, 15'd1608, 15'd3212, 15'd4808, 15'd6393, 15'd7962, 15'd9512, 15'd11039,
        15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519, 15'd20787,
        15'd22005, 15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245, 15'd28105,
        15'd28898, 15'd29621, 15'd30273, 15'd30852, 15'd31356, 15'd31785, 15'd32137,
        15'd32412, 15'd32609, 15'd32728, 15'd32767
    };

    localparam logic [FREQ_W-1:0] ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam logic [FREQ_W-1:0] COL_FREQ [3] = '{11'd1209, 11'd1336, 11'd1477};

    typedef logic [2:0] key_tbl_t [16];

    function automatic key_tbl_t build_key(input bit want_row);
        key_tbl_t t;
        for (int i = 0; i < 16; i++) begin
            t[i] = want_row ? 3'(i / 3) : 3'(i % 3);
        end
        return t;
    endfunction

    localparam key_tbl_t KEY_ROW = build_key(1'b1);
    localparam key_tbl_t KEY_COL = build_key(1'b0);

endpackage

### rtl/ttg_sine.sv
module ttg_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [15:0] sine
);
    import ttg_pkg::*;

    logic [14:0] w;
    logic [4:0]  idx;
    logic        sat;
    logic [14:0] base_next;
    logic [10:0] delta_next;
    logic [14:0] base_reg;
    logic [10:0] delta_reg;
    logic [8:0]  frac_reg;
    logic        neg_reg;
    logic [19:0] prod;
    logic [15:0] v;
    logic signed [15:0] sine_reg;

    always_comb begin
        w          = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
        idx        = w[13:9];
        sat        = w[14];
        base_next  = sat ? QSINE[32] : QSINE[6'(idx)];
        delta_next = sat ? 11'd0 : 11'(QSINE[6'(idx) + 6'd1] - QSINE[6'(idx)]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg  <= base_next;
            delta_reg <= delta_next;
            frac_reg  <= w[8:0];
            neg_reg   <= phase[15];
        end
    end

    always_comb begin
        prod = 20'(delta_reg) * 20'(frac_reg);
        v    = 16'(base_reg) + 16'(prod[19:9]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= neg_reg ? -$signed(v) : $signed(v);
        end
    end

    assign sine = sine_reg;

endmodule

### rtl/ttg_front.sv
module ttg_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [1:0]                     in_opcode,
    input  logic [3:0]                     in_key,
    input  logic [ttg_pkg::TIME_WIDTH-1:0] in_time,
    output logic                           push,
    output ttg_pkg::job_t                  push_job,
    output logic [1:0]                     busy
);
    import ttg_pkg::*;

    localparam int TW = TIME_WIDTH;

    logic              v1_reg, v2_reg, v3_reg;
    op_t               op1_reg, op2_reg;
    logic [3:0]        key1_reg, key2_reg;
    logic [TW-1:0]     t1_reg, t2_reg;
    logic [2*TW-1:0]   pa_reg, pb_reg, pc_reg;
    logic [RING_W-1:0]    ra2_reg;
    logic [RINGING_W-1:0] rb2_reg;
    logic [CHOP_W-1:0]    rc2_reg;
    job_t              job3_reg;

    logic [TW-1:0] qa, qb, qc, da, db, dc, ra, rb, rc;
    job_t          job_next;
    logic [TW-1:0] rr;
    logic [2:0]    row;
    logic [RING_W-1:0] r8w;

    always_comb begin
        qa = pa_reg[2*TW-1:TW];
        qb = pb_reg[2*TW-1:TW];
        qc = pc_reg[2*TW-1:TW];
        da = t1_reg - qa * TW'(RING_CYCLE);
        db = t1_reg - qb * TW'(RINGING_PERIOD);
        dc = t1_reg - qc * TW'(CHOP_PERIOD);
        ra = (da >= TW'(RING_CYCLE))     ? da - TW'(RING_CYCLE)     : da;
        rb = (db >= TW'(RINGING_PERIOD)) ? db - TW'(RINGING_PERIOD) : db;
        rc = (dc >= TW'(CHOP_PERIOD))    ? dc - TW'(CHOP_PERIOD)    : dc;
    end

    always_comb begin
        job_next = '0;
        job_next.op = op2_reg;

        if (ra2_reg >= RING_W'(3 * SAMPLE_RATE)) begin
            r8w = ra2_reg - RING_W'(3 * SAMPLE_RATE);
        end else if (ra2_reg >= RING_W'(2 * SAMPLE_RATE)) begin
            r8w = ra2_reg - RING_W'(2 * SAMPLE_RATE);
        end else if (ra2_reg >= RING_W'(SAMPLE_RATE)) begin
            r8w = ra2_reg - RING_W'(SAMPLE_RATE);
        end else begin
            r8w = ra2_reg;
        end
        job_next.r8 = R8_W'(r8w);

        row = KEY_ROW[key2_reg];
        case (op2_reg)
            OP_RING, OP_TEST: begin
                job_next.f1 = F_RING;
            end
            OP_RINGING: begin
                job_next.f1 = F_RINGING;
            end
            OP_TOUCH: begin
                job_next.f1 = (row < 3'd4) ? ROW_FREQ[row[1:0]] : '0;
                job_next.f2 = COL_FREQ[KEY_COL[key2_reg][1:0]];
            end
            default: begin
                job_next.f1 = '0;
            end
        endcase

        job_next.ring_on = (rb2_reg >= RINGING_W'(2 * SAMPLE_RATE)) &&
                           (rb2_reg <  RINGING_W'(3 * SAMPLE_RATE));

        rr = (op2_reg == OP_TEST) ? t2_reg : TW'(ra2_reg);
        if (rr < TW'(FADE_LEN)) begin
            job_next.outer   = OUT_COS;
            job_next.outer_n = RAMP_IDX_W'(rr);
        end else if (rr > TW'(ON_LEN - FADE_LEN) && rr < TW'(ON_LEN)) begin
            job_next.outer   = OUT_COS;
            job_next.outer_n = RAMP_IDX_W'(TW'(ON_LEN) - rr);
        end else if (rr >= TW'(ON_LEN)) begin
            job_next.outer   = OUT_ZERO;
        end else begin
            job_next.outer   = OUT_ONE;
        end

        if (rc2_reg > CHOP_W'(CHOP_PERIOD - CHOP_RAMP)) begin
            job_next.inner   = IN_FALL;
            job_next.inner_n = RAMP_IDX_W'(CHOP_W'(CHOP_PERIOD) - rc2_reg);
        end else if (rc2_reg < CHOP_W'(CHOP_RAMP)) begin
            job_next.inner   = IN_RISE;
            job_next.inner_n = RAMP_IDX_W'(rc2_reg);
        end else if (rc2_reg > CHOP_W'(CHOP_HALF - CHOP_RAMP) &&
                     rc2_reg < CHOP_W'(CHOP_HALF + CHOP_RAMP)) begin
            if (rc2_reg < CHOP_W'(CHOP_HALF)) begin
                job_next.inner   = IN_RISE;
                job_next.inner_n = RAMP_IDX_W'(CHOP_W'(CHOP_HALF) - rc2_reg);
            end else begin
                job_next.inner   = IN_FALL;
                job_next.inner_n = RAMP_IDX_W'(rc2_reg - CHOP_W'(CHOP_HALF));
            end
        end else if (rc2_reg <= CHOP_W'(CHOP_HALF)) begin
            job_next.inner   = IN_ONE;
        end else begin
            job_next.inner   = IN_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        op1_reg  <= op_t'(in_opcode);
        key1_reg <= in_key;
        t1_reg   <= in_time;
        pa_reg   <= (2*TW)'(in_time) * (2*TW)'(RECIP_RING);
        pb_reg   <= (2*TW)'(in_time) * (2*TW)'(RECIP_RINGING);
        pc_reg   <= (2*TW)'(in_time) * (2*TW)'(RECIP_CHOP);
        op2_reg  <= op1_reg;
        key2_reg <= key1_reg;
        t2_reg   <= t1_reg;
        ra2_reg  <= RING_W'(ra);
        rb2_reg  <= RINGING_W'(rb);
        rc2_reg  <= CHOP_W'(rc);
        job3_reg <= job_next;
    end

    assign push     = v3_reg;
    assign push_job = job3_reg;
    assign busy     = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);

endmodule

### rtl/ttg_fifo.sv
module ttg_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  ttg_pkg::job_t                push_job,
    input  logic                         pop,
    output ttg_pkg::job_t                head_job,
    output logic [ttg_pkg::QCNT_W-1:0]   count
);
    import ttg_pkg::*;

    job_t              mem_reg [QD];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    assign head_job = mem_reg[rd_reg];
    assign count    = cnt_reg;

endmodule

### rtl/ttg_back.sv
module ttg_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  ttg_pkg::job_t head_job,
    output logic          pop,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_code
);
    import ttg_pkg::*;

    localparam int NST = 10;

    typedef struct packed {
        op_t    op;
        logic   ring_on;
        outer_t outer;
        inner_t inner;
    } side_t;

    logic            en;
    logic [NST-1:0]  vld_reg;
    side_t           side_reg [NST];
    logic            m_valid_reg;
    logic [7:0]      m_code_reg;

    logic [15:0]         oph_reg [5];
    logic [15:0]         iph_reg [5];
    logic [X_W-1:0]      x_reg  [2];
    logic [X_W-1:0]      xc_reg [2];
    logic [2*X_W-1:0]    p_reg  [2];
    logic [R8_W-1:0]     xm_reg [2];
    logic [PH_NUM_W-1:0] num_reg [2];
    logic [2*PH_NUM_W-1:0] pp_reg [2];
    logic [15:0]         ph_reg [2];

    logic [X_W-1:0]      q3 [2];
    logic [X_W-1:0]      d3 [2];
    logic [PH_NUM_W-1:0] q5 [2];
    logic [PH_NUM_W-1:0] r5 [2];

    logic signed [15:0]  s1w, s2w, sow, siw;
    logic signed [15:0]  s1a_reg, s2a_reg, s1b_reg, s2b_reg;
    logic [15:0]         ofac_reg, ifac_reg, fac_reg;
    logic signed [17:0]  ocos, irise, ifall;
    logic [15:0]         ofac_next, ifac_next;
    logic [31:0]         facp;
    logic signed [32:0]  sf_reg;
    logic signed [24:0]  rg_reg;
    logic signed [26:0]  tt_reg;
    logic signed [41:0]  rt;
    logic signed [24:0]  gt;
    logic signed [26:0]  tu;
    logic [7:0]          code_next;

    assign en  = !m_valid_reg || out_ready;
    assign pop = en && head_valid;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q3[l] = p_reg[l][2*X_W-1:X_W];
            d3[l] = xc_reg[l] - q3[l] * X_W'(SAMPLE_RATE);
            q5[l] = pp_reg[l][2*PH_NUM_W-1:PH_NUM_W];
            r5[l] = num_reg[l] - q5[l] * PH_NUM_W'(SAMPLE_RATE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NST-2:0], pop};
            m_valid_reg <= vld_reg[NST-1];
        end
        if (en) begin
            side_reg[0] <= '{op: head_job.op, ring_on: head_job.ring_on,
                             outer: head_job.outer, inner: head_job.inner};
            for (int i = 1; i < NST; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            oph_reg[0] <= 16'(17'd16384 + 17'(RAMP_TBL[head_job.outer_n]));
            iph_reg[0] <= RAMP_TBL[head_job.inner_n];
            for (int i = 1; i < 5; i++) begin
                oph_reg[i] <= oph_reg[i-1];
                iph_reg[i] <= iph_reg[i-1];
            end
            x_reg[0] <= X_W'(head_job.f1) * X_W'(head_job.r8);
            x_reg[1] <= X_W'(head_job.f2) * X_W'(head_job.r8);
            for (int l = 0; l < 2; l++) begin
                p_reg[l]   <= (2*X_W)'(x_reg[l]) * (2*X_W)'(RECIP_X);
                xc_reg[l]  <= x_reg[l];
                xm_reg[l]  <= (d3[l] >= X_W'(SAMPLE_RATE)) ?
                              R8_W'(d3[l] - X_W'(SAMPLE_RATE)) : R8_W'(d3[l]);
                num_reg[l] <= {xm_reg[l], 16'd0};
                pp_reg[l]  <= (2*PH_NUM_W)'({xm_reg[l], 16'd0}) *
                              (2*PH_NUM_W)'(RECIP_PH);
                ph_reg[l]  <= 16'(q5[l] + PH_NUM_W'(r5[l] >= PH_NUM_W'(SAMPLE_RATE)));
            end
            s1a_reg  <= s1w;
            s2a_reg  <= s2w;
            ofac_reg <= ofac_next;
            ifac_reg <= ifac_next;
            s1b_reg  <= s1a_reg;
            s2b_reg  <= s2a_reg;
            fac_reg  <= facp[30:15];
            sf_reg   <= 33'(s1b_reg) * $signed({17'd0, fac_reg});
            rg_reg   <= (25'(s1b_reg) <<< 8) - 25'(s1b_reg);
            tt_reg   <= (27'(s1b_reg) + 27'(s2b_reg)) * 27'sd357;
            m_code_reg <= code_next;
        end
    end

    ttg_sine u_sine_t1 (.aclk(aclk), .en(en), .phase(ph_reg[0]), .sine(s1w));
    ttg_sine u_sine_t2 (.aclk(aclk), .en(en), .phase(ph_reg[1]), .sine(s2w));
    ttg_sine u_sine_o  (.aclk(aclk), .en(en), .phase(oph_reg[4]), .sine(sow));
    ttg_sine u_sine_i  (.aclk(aclk), .en(en), .phase(iph_reg[4]), .sine(siw));

    always_comb begin
        ocos  = 18'sd32768 - 18'(sow);
        irise = 18'sd32768 + 18'(siw);
        ifall = 18'sd32768 - 18'(siw);
        case (side_reg[6].outer)
            OUT_ONE:  ofac_next = 16'd32768;
            OUT_ZERO: ofac_next = 16'd0;
            OUT_COS:  ofac_next = ocos[16:1];
            default:  ofac_next = 16'd0;
        endcase
        case (side_reg[6].inner)
            IN_ONE:  ifac_next = 16'd32768;
            IN_ZERO: ifac_next = 16'd0;
            IN_RISE: ifac_next = irise[16:1];
            IN_FALL: ifac_next = ifall[16:1];
            default: ifac_next = 16'd0;
        endcase
        facp = 32'(ofac_reg) * 32'(ifac_reg);
    end

    always_comb begin
        rt = (42'(sf_reg) <<< 8) - 42'(sf_reg) + 42'sd273804165120;
        gt = rg_reg + 25'sd8355840;
        tu = tt_reg + 27'sd33423360;
        case (side_reg[NST-1].op)
            OP_RING, OP_TEST: code_next = rt[38:31];
            OP_RINGING:       code_next = side_reg[NST-1].ring_on ? gt[23:16] : 8'd128;
            OP_TOUCH:         code_next = tu[25:18];
            default:          code_next = 8'd128;
        endcase
    end

    assign out_valid = m_valid_reg;
    assign out_code  = m_code_reg;

endmodule

### rtl/telephone_tone_generator_top.sv
// Input-to-result time grows while the queue drains. Throughput: one sample per
// cycle while m_ready is high and the queue has room; front moduli run in 3
// stages, back tone and envelope pipeline in 11 stages with four shared-design
// sine units. Reset: aresetn, synchronous, active low, clears the valid bits,
// queue pointers and output valid; no sample state is kept.
module telephone_tone_generator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_opcode,
    input  logic [3:0]                     s_key_index,
    input  logic [ttg_pkg::TIME_WIDTH-1:0] s_sample_time,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_sample_code
);
    import ttg_pkg::*;

    `include "telephone_tone_generator_top_assert.svh"

    logic              push, pop;
    job_t              push_job, head_job;
    logic [1:0]        busy;
    logic [QCNT_W-1:0] fifo_count;

    assign s_ready = (fifo_count + QCNT_W'(busy)) < QCNT_W'(QD);

    ttg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && s_ready),
        .in_opcode (s_opcode),
        .in_key    (s_key_index),
        .in_time   (s_sample_time),
        .push      (push),
        .push_job  (push_job),
        .busy      (busy)
    );

    ttg_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .count    (fifo_count)
    );

    ttg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (fifo_count != '0),
        .head_job   (head_job),
        .pop        (pop),
        .out_ready  (m_ready),
        .out_valid  (m_valid),
        .out_code   (m_sample_code)
    );

    `TTG_ASSERT_NOW(a_no_overflow, push, fifo_count < QCNT_W'(QD))
    `TTG_ASSERT_NOW(a_pop_nonempty, pop, fifo_count != '0)
    `TTG_ASSERT_NEXT(a_count_drop, pop && !push, fifo_count == $past(fifo_count) - 1'b1)

endmodule

### tb/tone_checker.sv
module tone_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [3:0]  s_key_index,
    input  logic [31:0] s_sample_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_sample_code,
    output int          fail_count,
    output int          pending
);
    import ttg_pkg::*;

    localparam longint RATE = 8000;

    logic [7:0] code_queue[$];

    function automatic longint qsine(longint phase);
        longint p, quad, w, idx, frac, v;
        p = phase & 64'hFFFF;
        quad = p >> 14;
        w = p & 64'h3FFF;
        if (quad & 1) begin
            w = 16384 - w;
        end
        idx = w >> 9;
        frac = w & 9'h1FF;
        if (idx >= 32) begin
            v = QSINE[32];
        end else begin
            v = QSINE[idx] + (((QSINE[idx + 1] - QSINE[idx]) * frac) >> 9);
        end
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint tone_phase(longint freq, longint t);
        return (((freq * (t % RATE)) % RATE) * 65536) / RATE;
    endfunction

    function automatic longint raised_cos(longint u, longint span);
        return (32768 - qsine(16384 + (u * 32768) / span)) >>> 1;
    endfunction

    function automatic longint ramp(longint n, bit up);
        longint s;
        s = qsine((n * 65536) / (12 * RATE));
        return up ? ((32768 + s) >>> 1) : ((32768 - s) >>> 1);
    endfunction

    function automatic logic [7:0] predict_code(op_t op, logic [3:0] key, logic [31:0] tin);
        longint t, r, u, w, outer, inner, fac, s, s1, num;
        t = tin;
        if (op == OP_RING || op == OP_TEST) begin
            r = (op == OP_RING) ? (t % (4 * RATE)) : t;
            u = r * 1000;
            w = (t * 2000) % (88 * RATE);
            if (u < 3 * RATE) begin
                outer = raised_cos(u, 3 * RATE);
            end else if (u > 1297 * RATE && u < 1300 * RATE) begin
                outer = raised_cos(1300 * RATE - u, 3 * RATE);
            end else if (u >= 1300 * RATE) begin
                outer = 0;
            end else begin
                outer = 32768;
            end
            if (w > 85 * RATE) begin
                inner = ramp(88 * RATE - w, 1'b0);
            end else if (w < 3 * RATE) begin
                inner = ramp(w, 1'b1);
            end else if (w > 41 * RATE && w < 47 * RATE) begin
                inner = (w < 44 * RATE) ? ramp(44 * RATE - w, 1'b1)
                                        : ramp(w - 44 * RATE, 1'b0);
            end else if (w <= 44 * RATE) begin
                inner = 32768;
            end else begin
                inner = 0;
            end
            fac = (outer * inner) >> 15;
            s = qsine(tone_phase(1300, t));
            num = s * fac * 255 + 255 * (64'sd1 << 30);
            return 8'(num >> 31);
        end else if (op == OP_RINGING) begin
            r = t % (5 * RATE);
            if (r >= 2 * RATE && r < 3 * RATE) begin
                s = qsine(tone_phase(425, t));
                return 8'((s * 255 + 255 * 32768) >> 16);
            end
            return 8'd128;
        end
        s1 = 0;
        if (key / 3 < 4) begin
            s1 = qsine(tone_phase(ROW_FREQ[key / 3], t));
        end
        s = qsine(tone_phase(COL_FREQ[key % 3], t));
        num = (s1 + s) * 357 + 255 * (64'sd1 << 17);
        return 8'(num >> 18);
    endfunction

    assign pending = code_queue.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                code_queue.push_back(predict_code(op_t'(s_opcode), s_key_index, s_sample_time));
            end
            if (m_valid && m_ready) begin
                if (code_queue.size() == 0) begin
                    $display("%0t: unexpected sample_code, expected none, actual %0d",
                             $time, m_sample_code);
                    fail_count <= fail_count + 1;
                end else if (code_queue[0] !== m_sample_code) begin
                    $display("%0t: sample_code mismatch, expected %0d, actual %0d",
                             $time, code_queue[0], m_sample_code);
                    fail_count <= fail_count + 1;
                    void'(code_queue.pop_front());
                end else begin
                    void'(code_queue.pop_front());
                end
            end
        end
    end
endmodule

### tb/testbench.sv
module testbench;
    import ttg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL = 1700;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [3:0]  s_key_index;
    logic [31:0] s_sample_time;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_sample_code;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;

    telephone_tone_generator_top dut (.*);

    tone_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stall bursts on the result side
    initial begin
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
            if (!calm && $urandom_range(0, 1)) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(op_t op, logic [3:0] key, logic [31:0] t);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= op;
        s_key_index <= key;
        s_sample_time <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_time();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return $urandom();
            1: return $urandom_range(0, 48000);
            2: return 32000 * $urandom_range(0, 1000) + $urandom_range(0, 40);
            3: return 32000 * $urandom_range(0, 1000) + 10400 - $urandom_range(0, 40);
            4: return 352 * $urandom_range(0, 100000) + $urandom_range(0, 20);
            default: return 176 * $urandom_range(0, 100000) + 176 - $urandom_range(0, 15);
        endcase
    endfunction

    initial begin
        logic [31:0] edge_times[10];
        edge_times = '{0, 1, 23, 24, 10376, 10399, 10400, 16000, 23999, 32'hFFFFFFFF};
        aresetn = 0;
        s_valid = 0;
        s_opcode = OP_RING;
        s_key_index = 0;
        s_sample_time = 0;
        calm = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (edge_times[i]) begin
            send_sample(op_t'(i % 4), 4'(i), edge_times[i]);
        end
        for (int k = 0; k < 16; k++) begin
            send_sample(OP_TOUCH, 4'(k), $urandom());
        end
        for (int n = 0; n < TOTAL; n++) begin
            if (n == TOTAL - 200) begin
                calm = 1;
            end
            send_sample(op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), pick_time());
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### telephone_tone_generator_top.f
+incdir+rtl
rtl/ttg_pkg.sv
rtl/ttg_sine.sv
rtl/ttg_front.sv
rtl/ttg_fifo.sv
rtl/ttg_back.sv
rtl/telephone_tone_generator_top.sv
tb/tone_checker.sv
tb/testbench.sv
